// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication or plain property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Widths, operation and status codes, and the decode record of the stack.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int WORD_W        = 32;
   localparam int LVL_W         = 9;
   localparam int DEPTH_DEFAULT = 256;

   // Operation codes on req_func.
   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_PEEK = 2'd2;

   // Status codes on rsp_status.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_UNDERFLW = 2'd2;
   localparam logic [1:0] STAT_BADPOS   = 2'd3;

   // Word returned on errors, for push, and for an empty stack.
   localparam logic signed [WORD_W-1:0] ERR_WORD = '1;

   // Capacity after reset.
   localparam logic [LVL_W-1:0] CAP_RESET = 9'd256;

   // Outcome of decoding one request against the current fill level.
   typedef struct packed {
      logic       push_ok;
      logic       pop_ok;
      logic       peek_ok;
      logic [1:0] status;
   } decision_type;

endpackage

// ===== rtl/lsp_decode.sv =====
// ----------------------------------------------------------------------------
// lsp_decode
// Checks a request against the fill level and the effective capacity.
// ----------------------------------------------------------------------------
module lsp_decode #(
   parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
   input  logic [1:0]              func,
   input  logic [lsp_pkg::LVL_W-1:0] position,
   input  logic [lsp_pkg::LVL_W-1:0] fill,
   input  logic [lsp_pkg::LVL_W-1:0] capacity,
   output logic [lsp_pkg::LVL_W-1:0] eff_cap,
   output lsp_pkg::decision_type    dec
);
   import lsp_pkg::*;

   // A capacity of zero acts as one, and anything above the depth as the depth.
   always_comb begin
      if (capacity == '0) begin
         eff_cap = LVL_W'(1);
      end else if (32'(capacity) > DEPTH) begin
         eff_cap = LVL_W'(DEPTH);
      end else begin
         eff_cap = capacity;
      end
   end

   // Decide whether the request touches the store or fails at once.
   always_comb begin
      dec = '0;
      case (func)
         FUNC_PUSH: begin
            if (fill >= eff_cap) begin
               dec.status = STAT_OVERFLOW;
            end else begin
               dec.push_ok = 1'b1;
            end
         end
         FUNC_POP: begin
            if (fill == '0) begin
               dec.status = STAT_UNDERFLW;
            end else begin
               dec.pop_ok = 1'b1;
            end
         end
         FUNC_PEEK: begin
            if (position == '0 || position > fill) begin
               dec.status = STAT_BADPOS;
            end else begin
               dec.peek_ok = 1'b1;
            end
         end
         default: begin
            dec.status = STAT_OK;
         end
      endcase
   end

endmodule

// ===== rtl/lifo_stack_with_peek_unit.sv =====
// A push, a failed request or an unused code gives its registered result in the
// cycle after start; a pop with data or a valid peek passes through the read state first.
// Throughput: one push per cycle while not busy; a pop or peek holds busy in the read
// state while the single memory read port returns its registered data.
// Reset clears the fill level to empty and capacity to 256; words are not cleared.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// lifo_stack_with_peek_unit
// Last-in first-out stack of signed words held in one synchronous memory,
// with push, pop and peek by depth from the top.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_unit #(
   parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_func,
   input  logic signed [lsp_pkg::WORD_W-1:0] req_push_value,
   input  logic [lsp_pkg::LVL_W-1:0]         req_position,
   output logic                             rsp_strobe,
   output logic signed [lsp_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                       rsp_status,
   output logic signed [lsp_pkg::WORD_W-1:0] rsp_top_value,
   output logic [lsp_pkg::LVL_W-1:0]         rsp_level,
   output logic                             rsp_full_res,
   output logic                             rsp_empty_res,
   input  logic                             csr_we,
   input  logic [lsp_pkg::LVL_W-1:0]         csr_wdata
);
   import lsp_pkg::*;

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type               state_ff, state_in;
   logic [LVL_W-1:0]        fill_ff, fill_in;
   logic [LVL_W-1:0]        cap_ff;
   logic signed [WORD_W-1:0] top_ff, top_in;
   logic                    pend_pop_ff, pend_pop_in;
   logic                    strobe_ff, strobe_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;
   logic [1:0]              stat_ff, stat_in;
   logic signed [WORD_W-1:0] rtop_ff, rtop_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic                    full_ff, full_in;
   logic                    empty_ff, empty_in;

   logic [WORD_W-1:0]       mem [DEPTH];
   logic signed [WORD_W-1:0] mem_q_ff;
   logic                    mem_we;
   logic [AW-1:0]           rd_addr;
   logic [LVL_W-1:0]        eff_cap;
   decision_type            dec;
   logic                    accept;
   logic signed [WORD_W-1:0] top_now;

   lsp_decode #(.DEPTH(DEPTH)) u_decode (
      .func     (req_func),
      .position (req_position),
      .fill     (fill_ff),
      .capacity (cap_ff),
      .eff_cap  (eff_cap),
      .dec      (dec)
   );

   assign accept  = start && (state_ff == S_IDLE);
   assign top_now = (fill_ff != '0) ? top_ff : ERR_WORD;

   // A pop reads the word below the top to become the new top; a peek reads
   // the word at its depth.
   assign rd_addr = (req_func == FUNC_POP) ? AW'(fill_ff - LVL_W'(2))
                                           : AW'(fill_ff - req_position);

   // Word store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(fill_ff)] <= req_push_value;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Next-state and result logic.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      top_in      = top_ff;
      pend_pop_in = pend_pop_ff;
      strobe_in   = 1'b0;
      rd_in       = rd_ff;
      stat_in     = stat_ff;
      rtop_in     = rtop_ff;
      lvl_in      = lvl_ff;
      full_in     = full_ff;
      empty_in    = empty_ff;
      mem_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (dec.push_ok) begin
                  // The pushed word is the new top; no read is needed.
                  mem_we    = 1'b1;
                  fill_in   = fill_ff + LVL_W'(1);
                  top_in    = req_push_value;
                  strobe_in = 1'b1;
                  rd_in     = ERR_WORD;
                  stat_in   = STAT_OK;
                  rtop_in   = req_push_value;
                  lvl_in    = fill_ff + LVL_W'(1);
                  full_in   = (fill_ff + LVL_W'(1)) >= eff_cap;
                  empty_in  = 1'b0;
               end else if (dec.pop_ok) begin
                  fill_in     = fill_ff - LVL_W'(1);
                  pend_pop_in = 1'b1;
                  state_in    = S_READ;
               end else if (dec.peek_ok) begin
                  pend_pop_in = 1'b0;
                  state_in    = S_READ;
               end else begin
                  // Failed request or unused code: nothing changes.
                  strobe_in = 1'b1;
                  rd_in     = ERR_WORD;
                  stat_in   = dec.status;
                  rtop_in   = top_now;
                  lvl_in    = fill_ff;
                  full_in   = fill_ff >= eff_cap;
                  empty_in  = (fill_ff == '0);
               end
            end
         end
         S_READ: begin
            // Memory data is back; the fill level already holds its new value.
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            stat_in   = STAT_OK;
            lvl_in    = fill_ff;
            full_in   = fill_ff >= eff_cap;
            empty_in  = (fill_ff == '0);
            if (pend_pop_ff) begin
               rd_in   = top_ff;
               top_in  = mem_q_ff;
               rtop_in = (fill_ff != '0) ? mem_q_ff : ERR_WORD;
            end else begin
               rd_in   = mem_q_ff;
               rtop_in = top_now;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, configuration and registered result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         cap_ff    <= CAP_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
      top_ff      <= top_in;
      pend_pop_ff <= pend_pop_in;
      rd_ff       <= rd_in;
      stat_ff     <= stat_in;
      rtop_ff     <= rtop_in;
      lvl_ff      <= lvl_in;
      full_ff     <= full_in;
      empty_ff    <= empty_in;
   end

   assign busy           = (state_ff == S_READ);
   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_status     = stat_ff;
   assign rsp_top_value  = rtop_ff;
   assign rsp_level      = lvl_ff;
   assign rsp_full_res   = full_ff;
   assign rsp_empty_res  = empty_ff;

   // The read state is left in the next cycle and always ends in a result beat.
   `ASSERT_ALWAYS(a_read_one_cycle, busy |=> (!busy && rsp_strobe), "read state not one cycle")
   // A pop of a non-empty stack must go through the memory read.
   `ASSERT_ALWAYS(a_pop_reads, (accept && dec.pop_ok) |=> busy, "pop did not start a read")
   // The empty flag of a result agrees with its level.
   `ASSERT_ALWAYS(a_empty_flag, rsp_strobe |-> (rsp_empty_res == (rsp_level == '0)),
                  "empty flag disagrees with level")
   // The fill level never passes the depth of the store.
   `ASSERT_NEVER(a_fill_depth, 32'(fill_ff) > DEPTH, "fill level beyond depth")

endmodule
